### sv/wfm_pkg.sv
// Shared types, constants and elaboration-time ROM functions for the windowed FFT magnitude block.
// Depends on nothing; imported by every wfm_* module.
`default_nettype none

package wfm_pkg;

	localparam int POINTS_DEF  = 128;
	localparam int SAMPLE_BITS = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int BIN_BITS    = 6;
	localparam int MAG_BITS    = 15;
	localparam int COEF_BITS   = 17;

	localparam logic [MAG_BITS-1:0] MAG_MAX = 15'h7fff;
	localparam logic [63:0] Q30_ONE = 64'd1 << 30;
	localparam logic [63:0] PI_Q30  = 64'd3373259426;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          batch_end;
	} item_t;

	typedef struct packed {
		logic                valid;
		logic                last;
		logic [BIN_BITS-1:0] index;
	} bin_ctl_t;

	typedef struct packed {
		logic signed [63:0] c;
		logic signed [63:0] s;
	} trig_t;

	// restoring division, used only while building ROM contents
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] rem;
		logic [63:0] q;
		rem = '0;
		q = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], n[b]};
			if (rem >= {1'b0, d}) begin
				rem = rem - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// angle k/den of a turn, 32-bit turns, rounded to nearest
	function automatic logic [31:0] turn_phase(input int k, input int den);
		logic [63:0] num;
		logic [63:0] q;
		num = (64'(k) << 33) + 64'(den);
		q = udiv64(num, 64'(den) << 1);
		return q[31:0];
	endfunction

	// Q30 Taylor series on one octant
	function automatic trig_t taylor(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		trig_t r;
		x2 = (x * x) >> 30;
		t = Q30_ONE - x2 / 72;
		t = Q30_ONE - ((x2 * t) >> 30) / 42;
		t = Q30_ONE - ((x2 * t) >> 30) / 20;
		t = Q30_ONE - ((x2 * t) >> 30) / 6;
		r.s = $signed((x * t) >> 30);
		t = Q30_ONE - x2 / 90;
		t = Q30_ONE - ((x2 * t) >> 30) / 56;
		t = Q30_ONE - ((x2 * t) >> 30) / 30;
		t = Q30_ONE - ((x2 * t) >> 30) / 12;
		t = Q30_ONE - ((x2 * t) >> 30) / 2;
		r.c = $signed(t);
		return r;
	endfunction

	function automatic trig_t cos_sin(input logic [31:0] ph);
		logic [63:0] f;
		trig_t a;
		trig_t b;
		trig_t r;
		f = {34'd0, ph[29:0]};
		if (f < (Q30_ONE >> 1)) begin
			a = taylor((f * PI_Q30) >> 31);
		end else begin
			b = taylor(((Q30_ONE - f) * PI_Q30) >> 31);
			a.c = b.s;
			a.s = b.c;
		end
		case (ph[31:30])
			2'd0: begin
				r.c = a.c;
				r.s = a.s;
			end
			2'd1: begin
				r.c = -a.s;
				r.s = a.c;
			end
			2'd2: begin
				r.c = -a.c;
				r.s = -a.s;
			end
			default: begin
				r.c = a.s;
				r.s = -a.c;
			end
		endcase
		return r;
	endfunction

	// Hann window, Q15, 0..32768
	function automatic logic signed [COEF_BITS-1:0] win_val(input int k, input int n);
		trig_t cs;
		logic signed [63:0] v;
		cs = cos_sin(turn_phase(k, n - 1));
		v = ($signed(Q30_ONE) - cs.c + 64'sd32768) >>> 16;
		return v[COEF_BITS-1:0];
	endfunction

	function automatic logic signed [COEF_BITS-1:0] tw_re_val(input int k, input int n);
		trig_t cs;
		logic signed [63:0] v;
		cs = cos_sin(turn_phase(k, n));
		v = (cs.c + 64'sd16384) >>> 15;
		return v[COEF_BITS-1:0];
	endfunction

	function automatic logic signed [COEF_BITS-1:0] tw_im_val(input int k, input int n);
		trig_t cs;
		logic signed [63:0] v;
		cs = cos_sin(turn_phase(k, n));
		v = -((cs.s + 64'sd16384) >>> 15);
		return v[COEF_BITS-1:0];
	endfunction

endpackage

`default_nettype wire

### sv/wfm_front.sv
// Input side: accepts sample transactions and queues them for the transform engine.
// Depends on wfm_pkg.
`default_nettype none

module wfm_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [wfm_pkg::SAMPLE_BITS-1:0]    sample,
	input  wire logic                               batch_end,
	output wfm_pkg::item_t                          q_item,
	output logic                                    q_valid,
	input  wire logic                               q_pop
);
	import wfm_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	item_t          queue_q [QUEUE_DEPTH];
	logic [PW-1:0]  rd_ptr_q;
	logic [PW-1:0]  wr_ptr_q;
	logic [CW-1:0]  count_q;
	logic           push;
	logic           pop;

	assign in_stall = (count_q == CW'(QUEUE_DEPTH));
	assign q_valid  = (count_q != '0);
	assign push     = in_valid && !in_stall;
	assign pop      = q_pop && q_valid;
	assign q_item   = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= '{sample: $signed(sample), batch_end: batch_end};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

### sv/wfm_fft.sv
// Transform engine: sample ring, Hann window, radix-2 DIT butterflies on a work memory,
// then hands bins one at a time to the magnitude unit. Depends on wfm_pkg.
`default_nettype none

module wfm_fft #(
	parameter int POINTS = wfm_pkg::POINTS_DEF,
	localparam int DW = wfm_pkg::SAMPLE_BITS + $clog2(POINTS) + 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire wfm_pkg::item_t        q_item,
	input  wire logic                  q_valid,
	output logic                       q_pop,
	output wfm_pkg::bin_ctl_t          bin_ctl,
	output logic signed [DW-1:0]       bin_re,
	output logic signed [DW-1:0]       bin_im,
	input  wire logic                  bin_ready
);
	import wfm_pkg::*;

	localparam int AW   = $clog2(POINTS);
	localparam int HW   = AW - 1;
	localparam int HALF = POINTS / 2;
	localparam int SW   = $clog2(AW);
	localparam int PW   = DW + COEF_BITS;
	localparam int ACCW = PW + 1;
	localparam logic signed [ACCW-1:0] RND_HALF = ACCW'(16384);

	typedef enum logic [3:0] {
		S_IDLE, S_LD_RD, S_LD_MUL, S_LD_WR,
		S_BF_RA, S_BF_RB, S_BF_M0, S_BF_M1, S_BF_M2, S_BF_M3, S_BF_M4,
		S_BF_WA, S_BF_WB, S_MG_RD, S_MG_WAIT
	} state_t;

	state_t state_q;

	logic signed [COEF_BITS-1:0] win_rom [POINTS];
	logic signed [COEF_BITS-1:0] twr_rom [HALF];
	logic signed [COEF_BITS-1:0] twi_rom [HALF];

	for (genvar g = 0; g < POINTS; g++) begin : g_win
		localparam logic signed [COEF_BITS-1:0] WIN = win_val(g, POINTS);
		assign win_rom[g] = WIN;
	end
	for (genvar g = 0; g < HALF; g++) begin : g_tw
		localparam logic signed [COEF_BITS-1:0] TWR = tw_re_val(g, POINTS);
		localparam logic signed [COEF_BITS-1:0] TWI = tw_im_val(g, POINTS);
		assign twr_rom[g] = TWR;
		assign twi_rom[g] = TWI;
	end

	function automatic logic [AW-1:0] bitrev(input logic [AW-1:0] v);
		logic [AW-1:0] r;
		for (int b = 0; b < AW; b++) begin
			r[b] = v[AW-1-b];
		end
		return r;
	endfunction

	function automatic logic signed [DW-1:0] rnd(input logic signed [ACCW-1:0] x);
		logic signed [ACCW-1:0] y;
		y = (x + RND_HALF) >>> 15;
		return y[DW-1:0];
	endfunction

	// control
	logic [AW-1:0] wp_q;
	logic [AW-1:0] ld_i_q;
	logic [SW-1:0] stage_q;
	logic [HW-1:0] bf_q;
	logic [HW-1:0] mi_q;
	logic [POINTS-1:0] ring_vld_q;

	// memories and datapath
	logic signed [SAMPLE_BITS-1:0] ring_q [POINTS];
	logic signed [SAMPLE_BITS-1:0] ring_rd_q;
	logic                          ring_rd_vld_q;
	logic [2*DW-1:0]               work_q [POINTS];
	logic [2*DW-1:0]               rd_data_q;
	logic [2*DW-1:0]               a_q;
	logic signed [PW-1:0]          prod_q;
	logic signed [ACCW-1:0]        acc_q;
	logic signed [DW-1:0]          t_re_q;
	logic signed [DW-1:0]          t_im_q;

	logic                    ring_we;
	logic [AW-1:0]           ring_raddr;
	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic [2*DW-1:0]         wr_data;
	logic signed [DW-1:0]    mul_a;
	logic signed [COEF_BITS-1:0] mul_b;
	logic signed [PW-1:0]    mul_p;
	logic [HW-1:0]           j_idx;
	logic [HW-1:0]           grp;
	logic [HW-1:0]           tw_idx;
	logic [AW-1:0]           a_addr;
	logic [AW-1:0]           b_addr;
	logic signed [DW-1:0]    b_re;
	logic signed [DW-1:0]    b_im;
	logic signed [DW-1:0]    a_re;
	logic signed [DW-1:0]    a_im;
	logic signed [COEF_BITS-1:0] w_re;
	logic signed [COEF_BITS-1:0] w_im;

	// butterfly addressing: a = group*len + j, b = a + len/2, twiddle = j*stride
	assign j_idx  = bf_q & HW'((1 << stage_q) - 1);
	assign grp    = bf_q >> stage_q;
	assign tw_idx = j_idx << (SW'(HW) - stage_q);
	assign a_addr = (AW'(grp) << ({1'b0, stage_q} + 1'b1)) | AW'(j_idx);
	assign b_addr = a_addr | (AW'(1) << stage_q);

	assign b_re = $signed(rd_data_q[2*DW-1:DW]);
	assign b_im = $signed(rd_data_q[DW-1:0]);
	assign a_re = $signed(a_q[2*DW-1:DW]);
	assign a_im = $signed(a_q[DW-1:0]);
	assign w_re = twr_rom[tw_idx];
	assign w_im = twi_rom[tw_idx];

	assign q_pop      = (state_q == S_IDLE);
	assign ring_we    = (state_q == S_IDLE) && q_valid;
	assign ring_raddr = wp_q + ld_i_q;

	always_comb begin
		mul_a = b_re;
		mul_b = w_re;
		case (state_q)
			S_LD_MUL: begin
				mul_a = ring_rd_vld_q ? DW'(ring_rd_q) : '0;
				mul_b = win_rom[ld_i_q];
			end
			S_BF_M1: begin
				mul_a = b_im;
				mul_b = w_im;
			end
			S_BF_M2: begin
				mul_a = b_re;
				mul_b = w_im;
			end
			S_BF_M3: begin
				mul_a = b_im;
				mul_b = w_re;
			end
			default: begin
				mul_a = b_re;
				mul_b = w_re;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = a_addr;
		wr_en   = 1'b0;
		wr_addr = a_addr;
		wr_data = {a_re + t_re_q, a_im + t_im_q};
		case (state_q)
			S_BF_RA: rd_en = 1'b1;
			S_BF_RB: begin
				rd_en   = 1'b1;
				rd_addr = b_addr;
			end
			S_MG_RD: begin
				rd_en   = 1'b1;
				rd_addr = AW'(mi_q);
			end
			S_LD_WR: begin
				wr_en   = 1'b1;
				wr_addr = bitrev(ld_i_q);
				wr_data = {rnd(ACCW'(prod_q)), DW'(0)};
			end
			S_BF_WA: wr_en = 1'b1;
			S_BF_WB: begin
				wr_en   = 1'b1;
				wr_addr = b_addr;
				wr_data = {a_re - t_re_q, a_im - t_im_q};
			end
			default: ;
		endcase
	end

	assign bin_ctl.valid = (state_q == S_MG_WAIT);
	assign bin_ctl.last  = (mi_q == HW'(HALF - 1));
	assign bin_ctl.index = BIN_BITS'(mi_q);
	assign bin_re = b_re;
	assign bin_im = b_im;

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_q[wp_q] <= q_item.sample;
		end
		ring_rd_q     <= ring_q[ring_raddr];
		ring_rd_vld_q <= ring_vld_q[ring_raddr];
		if (wr_en) begin
			work_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= work_q[rd_addr];
		end
		if (state_q == S_BF_RB) begin
			a_q <= rd_data_q;
		end
		case (state_q)
			S_LD_MUL, S_BF_M0: prod_q <= mul_p;
			S_BF_M1: begin
				prod_q <= mul_p;
				acc_q  <= ACCW'(prod_q);
			end
			S_BF_M2: begin
				prod_q <= mul_p;
				t_re_q <= rnd(acc_q - ACCW'(prod_q));
			end
			S_BF_M3: begin
				prod_q <= mul_p;
				acc_q  <= ACCW'(prod_q);
			end
			S_BF_M4: t_im_q <= rnd(acc_q + ACCW'(prod_q));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			wp_q       <= '0;
			ld_i_q     <= '0;
			stage_q    <= '0;
			bf_q       <= '0;
			mi_q       <= '0;
			ring_vld_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						ring_vld_q[wp_q] <= 1'b1;
						wp_q <= wp_q + 1'b1;
						if (q_item.batch_end) begin
							ld_i_q  <= '0;
							state_q <= S_LD_RD;
						end
					end
				end
				S_LD_RD:  state_q <= S_LD_MUL;
				S_LD_MUL: state_q <= S_LD_WR;
				S_LD_WR: begin
					ld_i_q <= ld_i_q + 1'b1;
					if (ld_i_q == '1) begin
						stage_q <= '0;
						bf_q    <= '0;
						state_q <= S_BF_RA;
					end else begin
						state_q <= S_LD_RD;
					end
				end
				S_BF_RA: state_q <= S_BF_RB;
				S_BF_RB: state_q <= S_BF_M0;
				S_BF_M0: state_q <= S_BF_M1;
				S_BF_M1: state_q <= S_BF_M2;
				S_BF_M2: state_q <= S_BF_M3;
				S_BF_M3: state_q <= S_BF_M4;
				S_BF_M4: state_q <= S_BF_WA;
				S_BF_WA: state_q <= S_BF_WB;
				S_BF_WB: begin
					if (bf_q == HW'(HALF - 1)) begin
						bf_q <= '0;
						if (stage_q == SW'(AW - 1)) begin
							mi_q    <= '0;
							state_q <= S_MG_RD;
						end else begin
							stage_q <= stage_q + 1'b1;
							state_q <= S_BF_RA;
						end
					end else begin
						bf_q    <= bf_q + 1'b1;
						state_q <= S_BF_RA;
					end
				end
				S_MG_RD: state_q <= S_MG_WAIT;
				S_MG_WAIT: begin
					if (bin_ready) begin
						mi_q <= mi_q + 1'b1;
						state_q <= (mi_q == HW'(HALF - 1)) ? S_IDLE : S_MG_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_batch_starts_load: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && q_valid && q_item.batch_end) |=> (state_q == S_LD_RD))
		else $error("batch end did not start the window load");

	a_ring_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> $stable(wp_q))
		else $error("ring pointer moved during a transform");

endmodule

`default_nettype wire

### sv/wfm_mag.sv
// Magnitude unit: squares, bit-serial integer square root, scaling and the output register.
// Depends on wfm_pkg.
`default_nettype none

module wfm_mag #(
	parameter int POINTS = wfm_pkg::POINTS_DEF,
	localparam int DW = wfm_pkg::SAMPLE_BITS + $clog2(POINTS) + 1
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire wfm_pkg::bin_ctl_t             bin_ctl,
	input  wire logic signed [DW-1:0]          bin_re,
	input  wire logic signed [DW-1:0]          bin_im,
	output logic                               bin_ready,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output logic [wfm_pkg::BIN_BITS-1:0]       bin_index,
	output logic [wfm_pkg::MAG_BITS-1:0]       magnitude,
	output logic                               last_bin
);
	import wfm_pkg::*;

	localparam int AW   = $clog2(POINTS);
	localparam int HALF = POINTS / 2;
	localparam int RW   = DW + 1;
	localparam int VW   = 2 * RW;

	typedef enum logic [2:0] {M_IDLE, M_SQ_RE, M_SQ_IM, M_SUM, M_ROOT, M_DONE} state_t;

	state_t state_q;
	logic   out_valid_q;

	logic [DW-1:0]       abs_re_q;
	logic [DW-1:0]       abs_im_q;
	logic [2*DW-1:0]     sq_q;
	logic [VW-1:0]       val_q;
	logic [VW-1:0]       root_q;
	logic [VW-1:0]       bit_q;
	bin_ctl_t            ctl_q;
	logic [BIN_BITS-1:0] bin_index_q;
	logic [MAG_BITS-1:0] magnitude_q;
	logic                last_q;

	logic [DW-1:0]  sq_op;
	logic [VW-1:0]  trial;
	logic [VW-1:0]  scaled;
	logic           load_out;

	assign bin_ready = (state_q == M_IDLE);
	assign sq_op     = (state_q == M_SQ_RE) ? abs_re_q : abs_im_q;
	assign trial     = root_q + bit_q;
	assign scaled    = root_q >> (AW - 1);
	assign load_out  = (state_q == M_DONE) && (!out_valid_q || !out_stall);

	assign out_valid = out_valid_q;
	assign bin_index = bin_index_q;
	assign magnitude = magnitude_q;
	assign last_bin  = last_q;

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				ctl_q    <= bin_ctl;
				abs_re_q <= bin_re[DW-1] ? (~bin_re + 1'b1) : bin_re;
				abs_im_q <= bin_im[DW-1] ? (~bin_im + 1'b1) : bin_im;
			end
			M_SQ_RE: sq_q <= sq_op * sq_op;
			M_SQ_IM: begin
				val_q <= VW'(sq_q);
				sq_q  <= sq_op * sq_op;
			end
			M_SUM: begin
				val_q  <= val_q + VW'(sq_q);
				root_q <= '0;
				bit_q  <= VW'(1) << (VW - 2);
			end
			M_ROOT: begin
				if (val_q >= trial) begin
					val_q  <= val_q - trial;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			default: ;
		endcase
		if (load_out) begin
			bin_index_q <= ctl_q.index;
			last_q      <= ctl_q.last;
			magnitude_q <= (scaled > VW'(MAG_MAX)) ? MAG_MAX : scaled[MAG_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= M_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				M_IDLE:  if (bin_ctl.valid) state_q <= M_SQ_RE;
				M_SQ_RE: state_q <= M_SQ_IM;
				M_SQ_IM: state_q <= M_SUM;
				M_SUM:   state_q <= M_ROOT;
				M_ROOT:  if (bit_q[0]) state_q <= M_DONE;
				M_DONE:  if (load_out) state_q <= M_IDLE;
				default: state_q <= M_IDLE;
			endcase
		end
	end

	a_last_is_top_bin: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && last_q) |-> (bin_index_q == BIN_BITS'(HALF - 1)))
		else $error("last bin flag on wrong bin");

endmodule

`default_nettype wire

### sv/windowed_fft_magnitude.sv
// Top level of the windowed FFT magnitude block: input queue, transform engine, magnitude unit.
// Depends on wfm_pkg, wfm_front, wfm_fft, wfm_mag.
//
// Input channel (in_valid/in_stall, sample, batch_end): one signed Q1.15 sample per
// transaction, written into a ring of the last POINTS samples. A transaction with
// batch_end set also starts a transform of the ring, oldest sample first.
// Output channel (out_valid/out_stall, bin_index, magnitude, last_bin): POINTS/2
// transactions per batch, bins in ascending order, last_bin set on the final bin.
// Plain samples take one cycle each while the engine is idle; a short queue absorbs
// inputs while a transform runs and in_stall rises when it fills.
// A batch runs a window load of the ring, then (POINTS/2)*log2(POINTS) butterflies (one
// shared multiplier, single-port work memory), then the square-root unit on each bin in
// turn; the next queued sample is taken only after the magnitude unit has taken the last bin.
// A stalled output holds its bin and backs the engine up; nothing is dropped.
// Reset clears the ring (through per-entry valid bits), the pointers and the queue.
`default_nettype none

module windowed_fft_magnitude #(
	parameter int POINTS = wfm_pkg::POINTS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [wfm_pkg::SAMPLE_BITS-1:0]   sample,
	input  wire logic                              batch_end,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [wfm_pkg::BIN_BITS-1:0]           bin_index,
	output logic [wfm_pkg::MAG_BITS-1:0]           magnitude,
	output logic                                   last_bin
);
	import wfm_pkg::*;

	localparam int DW = SAMPLE_BITS + $clog2(POINTS) + 1;

	item_t                q_item;
	logic                 q_valid;
	logic                 q_pop;
	bin_ctl_t             bin_ctl;
	logic signed [DW-1:0] bin_re;
	logic signed [DW-1:0] bin_im;
	logic                 bin_ready;

	wfm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.batch_end (batch_end),
		.q_item    (q_item),
		.q_valid   (q_valid),
		.q_pop     (q_pop)
	);

	wfm_fft #(.POINTS(POINTS)) u_fft (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_item    (q_item),
		.q_valid   (q_valid),
		.q_pop     (q_pop),
		.bin_ctl   (bin_ctl),
		.bin_re    (bin_re),
		.bin_im    (bin_im),
		.bin_ready (bin_ready)
	);

	wfm_mag #(.POINTS(POINTS)) u_mag (
		.clk       (clk),
		.arst_n    (arst_n),
		.bin_ctl   (bin_ctl),
		.bin_re    (bin_re),
		.bin_im    (bin_im),
		.bin_ready (bin_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bin_index (bin_index),
		.magnitude (magnitude),
		.last_bin  (last_bin)
	);

endmodule

`default_nettype wire
